// File: rtl/ntlt_pkg.sv
// Shared constants and types of the N-Triples line tokenizer.
package ntlt_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned LenW  = 3;

  localparam logic [CharW-1:0] CharBackslash = 8'h5C;
  localparam logic [CharW-1:0] CharQuote     = 8'h22;
  localparam logic [CharW-1:0] CharSpace     = 8'h20;
  localparam logic [CharW-1:0] CharHash      = 8'h23;
  localparam logic [LenW-1:0]  MinLength     = 3'd7;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_EOL  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    TAG_SUBJECT   = 2'd0,
    TAG_PREDICATE = 2'd1,
    TAG_OBJECT    = 2'd2,
    TAG_NONE      = 2'd3
  } field_tag_e;

endpackage

// File: rtl/ntlt_if.sv
// Handshake channels for input beats and result beats.
interface ntlt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;

  modport source (output valid, kind, char_in, input ready);
  modport sink   (input valid, kind, char_in, output ready);
endinterface

interface ntlt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [1:0] field_tag;
  logic       line_done;
  logic       line_valid;
  logic       object_literal;

  modport source (output valid, char_out, field_tag, line_done, line_valid, object_literal,
                  input ready);
  modport sink   (input valid, char_out, field_tag, line_done, line_valid, object_literal,
                  output ready);
endinterface

// File: rtl/ntlt_in_stage.sv
// Input register stage: holds one accepted input beat.
module ntlt_in_stage import ntlt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ntlt_in_if.sink   in_i,
  ntlt_in_if.source out_o
);

  logic             valid_q;
  logic             kind_q;
  logic [CharW-1:0] char_q;

  assign in_i.ready = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      char_q <= in_i.char_in;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.kind    = kind_q;
  assign out_o.char_in = char_q;

endmodule

// File: rtl/ntlt_parse.sv
// Line state and per-beat tagging logic.
module ntlt_parse import ntlt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntlt_in_if.sink    in_i,
  ntlt_out_if.source out_o
);

  logic            escape_q, escape_d;
  logic            quotes_q, quotes_d;
  logic [1:0]      closed_q, closed_d;
  logic            has_chars_q, has_chars_d;
  logic            literal_q, literal_d;
  logic [LenW-1:0] length_q, length_d;
  logic            hash_q, hash_d;
  logic            fire;
  logic            ok_shape;
  field_tag_e      tag;

  assign in_i.ready  = out_o.ready;
  assign out_o.valid = in_i.valid;
  assign fire        = in_i.valid && out_o.ready;
  assign ok_shape    = (length_q == MinLength) && !hash_q;

  always_comb begin
    escape_d    = escape_q;
    quotes_d    = quotes_q;
    closed_d    = closed_q;
    has_chars_d = has_chars_q;
    literal_d   = literal_q;
    length_d    = length_q;
    hash_d      = hash_q;
    tag         = TAG_NONE;
    if (in_i.kind == KIND_EOL) begin
      escape_d    = 1'b0;
      quotes_d    = 1'b0;
      closed_d    = 2'd0;
      has_chars_d = 1'b0;
      literal_d   = 1'b0;
      length_d    = '0;
      hash_d      = 1'b0;
    end else begin
      if (length_q == '0 && in_i.char_in == CharHash) begin
        hash_d = 1'b1;
      end
      if (length_q != MinLength) begin
        length_d = length_q + LenW'(1);
      end
      if (field_tag_e'(closed_q) != TAG_NONE) begin
        if (in_i.char_in == CharBackslash) begin
          escape_d    = !escape_q;
          has_chars_d = 1'b1;
          tag         = field_tag_e'(closed_q);
        end else begin
          escape_d = 1'b0;
          if (!escape_q && in_i.char_in == CharQuote) begin
            quotes_d    = !quotes_q;
            has_chars_d = 1'b1;
            tag         = field_tag_e'(closed_q);
            if (field_tag_e'(closed_q) == TAG_OBJECT && !quotes_q) begin
              literal_d = 1'b1;
            end
          end else if (in_i.char_in == CharSpace && !quotes_q) begin
            if (has_chars_q) begin
              closed_d = closed_q + 2'd1;
            end
            has_chars_d = 1'b0;
          end else begin
            has_chars_d = 1'b1;
            tag         = field_tag_e'(closed_q);
          end
        end
      end
    end
  end

  always_comb begin
    if (in_i.kind == KIND_EOL) begin
      out_o.char_out       = '0;
      out_o.field_tag      = TAG_NONE;
      out_o.line_done      = 1'b1;
      out_o.line_valid     = ok_shape && (field_tag_e'(closed_q) == TAG_NONE);
      out_o.object_literal = ok_shape && literal_q;
    end else begin
      out_o.char_out       = in_i.char_in;
      out_o.field_tag      = tag;
      out_o.line_done      = 1'b0;
      out_o.line_valid     = 1'b0;
      out_o.object_literal = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q    <= 1'b0;
      quotes_q    <= 1'b0;
      closed_q    <= 2'd0;
      has_chars_q <= 1'b0;
      literal_q   <= 1'b0;
      length_q    <= '0;
      hash_q      <= 1'b0;
    end else if (fire) begin
      escape_q    <= escape_d;
      quotes_q    <= quotes_d;
      closed_q    <= closed_d;
      has_chars_q <= has_chars_d;
      literal_q   <= literal_d;
      length_q    <= length_d;
      hash_q      <= hash_d;
    end
  end

endmodule

// File: rtl/ntlt_out_stage.sv
// Result register stage: holds one result beat until it is taken.
module ntlt_out_stage import ntlt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntlt_out_if.sink   in_i,
  ntlt_out_if.source out_o
);

  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic [1:0]       tag_q;
  logic             done_q;
  logic             line_valid_q;
  logic             literal_q;

  assign in_i.ready = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q       <= in_i.char_out;
      tag_q        <= in_i.field_tag;
      done_q       <= in_i.line_done;
      line_valid_q <= in_i.line_valid;
      literal_q    <= in_i.object_literal;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.char_out       = char_q;
  assign out_o.field_tag      = tag_q;
  assign out_o.line_done      = done_q;
  assign out_o.line_valid     = line_valid_q;
  assign out_o.object_literal = literal_q;

endmodule

// File: rtl/ntriples_line_tokenizer.sv
// N-Triples line tokenizer: top level joining input stage, parser and result stage.
// Path: input register, then the combinational parser, then the result register.
// Throughput: one beat per cycle while out_o.ready is high; each of the input register
// and the result register takes a new beat when it is empty or its contents leave.
// Reset: asynchronous, active low; clears both stage valid bits and all line state.
module ntriples_line_tokenizer import ntlt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntlt_in_if.sink    in_i,
  ntlt_out_if.source out_o
);

  ntlt_in_if  stage_in ();
  ntlt_out_if stage_res ();

  ntlt_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (stage_in)
  );

  ntlt_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stage_in),
    .out_o  (stage_res)
  );

  ntlt_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stage_res),
    .out_o  (out_o)
  );

  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_res.valid && stage_res.ready) |=> out_o.valid)
    else $error("result beat lost between parser and result register");

  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> stage_in.valid)
    else $error("input beat lost in input register");

  a_eol_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.line_done) |->
      (out_o.field_tag == TAG_NONE && out_o.char_out == '0))
    else $error("end-of-line result carries byte data");

  a_byte_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.line_done) |-> (!out_o.line_valid && !out_o.object_literal))
    else $error("byte result carries line flags");

endmodule

// File: bench/ntriples_line_tokenizer_tb.sv
// Self-checking bench for the N-Triples line tokenizer: directed table, random lines, predictor.
module ntriples_line_tokenizer_tb import ntlt_pkg::*; ();

  typedef struct packed {
    logic [CharW-1:0] ch;
    field_tag_e       tag;
    logic             done;
    logic             ok;
    logic             lit;
  } tok_beat_t;

  typedef struct packed {
    kind_e            k;
    logic [CharW-1:0] c;
    logic             typed;
    tok_beat_t        want;
  } stim_row_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TotalBeats = 1350;
  localparam int unsigned DirCount   = 25;
  localparam logic [1:0]  AllFields  = 2'd3;

  localparam tok_beat_t EolBad  = '{8'h00, TAG_NONE, 1'b1, 1'b0, 1'b0};
  localparam tok_beat_t EolGood = '{8'h00, TAG_NONE, 1'b1, 1'b1, 1'b1};

  localparam stim_row_t DirRows [DirCount] = '{
    '{KIND_EOL,  8'h00,         1'b1, EolBad},
    '{KIND_CHAR, 8'h00,         1'b1, '{8'h00, TAG_SUBJECT, 1'b0, 1'b0, 1'b0}},
    '{KIND_CHAR, CharSpace,     1'b0, '0},
    '{KIND_CHAR, 8'hFF,         1'b1, '{8'hFF, TAG_PREDICATE, 1'b0, 1'b0, 1'b0}},
    '{KIND_CHAR, CharSpace,     1'b0, '0},
    '{KIND_CHAR, CharQuote,     1'b0, '0},
    '{KIND_CHAR, CharBackslash, 1'b0, '0},
    '{KIND_CHAR, CharQuote,     1'b0, '0},
    '{KIND_CHAR, CharSpace,     1'b0, '0},
    '{KIND_CHAR, CharQuote,     1'b0, '0},
    '{KIND_CHAR, CharSpace,     1'b0, '0},
    '{KIND_CHAR, 8'h80,         1'b1, '{8'h80, TAG_NONE, 1'b0, 1'b0, 1'b0}},
    '{KIND_EOL,  8'hFF,         1'b1, EolGood},
    '{KIND_CHAR, CharHash,      1'b0, '0},
    '{KIND_CHAR, 8'h78,         1'b0, '0},
    '{KIND_CHAR, CharSpace,     1'b0, '0},
    '{KIND_CHAR, CharSpace,     1'b0, '0},
    '{KIND_CHAR, 8'h79,         1'b0, '0},
    '{KIND_CHAR, CharSpace,     1'b0, '0},
    '{KIND_CHAR, 8'h7A,         1'b0, '0},
    '{KIND_CHAR, CharSpace,     1'b0, '0},
    '{KIND_EOL,  8'h00,         1'b1, EolBad},
    '{KIND_CHAR, 8'h61,         1'b0, '0},
    '{KIND_CHAR, CharBackslash, 1'b0, '0},
    '{KIND_EOL,  8'h00,         1'b1, EolBad}
  };

  logic clk;
  logic rst_n;

  ntlt_in_if  in_if ();
  ntlt_out_if out_if ();

  ntriples_line_tokenizer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic       esc_pending = 1'b0;
  logic       quoted      = 1'b0;
  logic [1:0] closed      = 2'd0;
  logic       has_chars   = 1'b0;
  logic       lit_seen    = 1'b0;
  logic [2:0] len_seen    = 3'd0;
  logic       hash_first  = 1'b0;

  tok_beat_t        pending_tokens [$];
  logic [CharW-1:0] line_bytes [$];

  int  beats_sent    = 0;
  int  lines_sent    = 0;
  int  results_seen  = 0;
  int  valid_lines   = 0;
  int  literal_lines = 0;
  int  input_stalls  = 0;
  int  errors        = 0;
  int  cycles        = 0;
  int  hold_req      = 0;
  int  stall_left    = 0;
  logic calm         = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic tok_beat_t tokenize_beat(input kind_e k, input logic [CharW-1:0] c);
    tok_beat_t r;
    logic      shape_ok;
    r = '{8'h00, TAG_NONE, 1'b0, 1'b0, 1'b0};
    if (k == KIND_EOL) begin
      shape_ok = (len_seen == MinLength) && !hash_first;
      r.done = 1'b1;
      r.ok   = shape_ok && (closed == AllFields);
      r.lit  = shape_ok && lit_seen;
      esc_pending = 1'b0;
      quoted      = 1'b0;
      closed      = 2'd0;
      has_chars   = 1'b0;
      lit_seen    = 1'b0;
      len_seen    = 3'd0;
      hash_first  = 1'b0;
      return r;
    end
    r.ch = c;
    if (len_seen == 3'd0 && c == CharHash) hash_first = 1'b1;
    if (len_seen != MinLength) len_seen = len_seen + 3'd1;
    if (closed != AllFields) begin
      if (c == CharBackslash) begin
        esc_pending = !esc_pending;
        has_chars   = 1'b1;
        r.tag       = field_tag_e'(closed);
      end else begin
        if (!esc_pending && c == CharQuote) begin
          quoted = !quoted;
          if (field_tag_e'(closed) == TAG_OBJECT && quoted) lit_seen = 1'b1;
          has_chars = 1'b1;
          r.tag     = field_tag_e'(closed);
        end else if (c == CharSpace && !quoted) begin
          if (has_chars) closed = closed + 2'd1;
          has_chars = 1'b0;
        end else begin
          has_chars = 1'b1;
          r.tag     = field_tag_e'(closed);
        end
        esc_pending = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [CharW-1:0] token_byte();
    logic [CharW-1:0] b;
    if ($urandom_range(0, 7) == 0) begin
      b = 8'($urandom);
      if (b == CharSpace || b == CharQuote || b == CharBackslash) b = 8'h00;
    end else begin
      b = 8'($urandom_range(8'h21, 8'h7E));
      if (b == CharQuote || b == CharBackslash) b = 8'h41;
    end
    return b;
  endfunction

  function automatic logic [CharW-1:0] noise_byte();
    case ($urandom_range(0, 9))
      0, 1:    return CharSpace;
      2:       return CharQuote;
      3:       return CharBackslash;
      4:       return CharHash;
      5, 6:    return token_byte();
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic build_triple_line();
    int n;
    line_bytes.delete();
    if ($urandom_range(0, 11) == 0) line_bytes.push_back(CharHash);
    if ($urandom_range(0, 5) == 0) line_bytes.push_back(CharSpace);
    for (int f = 0; f < 3; f++) begin
      if (f == 2 && $urandom_range(0, 1) == 1) begin
        line_bytes.push_back(CharQuote);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: line_bytes.push_back(CharSpace);
            1: begin
              line_bytes.push_back(CharBackslash);
              line_bytes.push_back(CharQuote);
            end
            2: begin
              line_bytes.push_back(CharBackslash);
              line_bytes.push_back(CharBackslash);
            end
            default: line_bytes.push_back(token_byte());
          endcase
        end
        if ($urandom_range(0, 7) != 0) line_bytes.push_back(CharQuote);
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          line_bytes.push_back(($urandom_range(0, 11) == 0) ? CharBackslash : token_byte());
      end
      n = (f == 2 && $urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      repeat (n) line_bytes.push_back(CharSpace);
    end
    if ($urandom_range(0, 1) == 1) line_bytes.push_back(8'h2E);
    n = $urandom_range(0, 2);
    repeat (n) line_bytes.push_back(noise_byte());
  endtask

  task automatic build_noise_line();
    int n;
    line_bytes.delete();
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 20);
    repeat (n) line_bytes.push_back(noise_byte());
  endtask

  task automatic send_beat(input kind_e k, input logic [CharW-1:0] c, input logic typed,
                           input tok_beat_t want);
    int        gap;
    int        r;
    tok_beat_t model;
    r = $urandom_range(0, 99);
    if (calm || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= k;
    in_if.char_in <= c;
    do @(posedge clk); while (!in_if.ready);
    model = tokenize_beat(k, c);
    pending_tokens.push_back(typed ? want : model);
    beats_sent++;
    if (k == KIND_EOL) lines_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (calm || $urandom_range(0, 99) < 65) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin : check_results
    tok_beat_t want;
    if (rst_n && in_if.valid && !in_if.ready) input_stalls++;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.line_done && out_if.line_valid) valid_lines++;
      if (out_if.line_done && out_if.object_literal) literal_lines++;
      if (pending_tokens.size() == 0) begin
        $display("%0t: result beat with nothing expected, char_out %h", $time, out_if.char_out);
        errors++;
      end else begin
        want = pending_tokens.pop_front();
        if (out_if.char_out !== want.ch) begin
          $display("%0t: char_out expected %h actual %h", $time, want.ch, out_if.char_out);
          errors++;
        end
        if (out_if.field_tag !== want.tag) begin
          $display("%0t: field_tag expected %0d actual %0d", $time, want.tag, out_if.field_tag);
          errors++;
        end
        if (out_if.line_done !== want.done) begin
          $display("%0t: line_done expected %b actual %b", $time, want.done, out_if.line_done);
          errors++;
        end
        if (out_if.line_valid !== want.ok) begin
          $display("%0t: line_valid expected %b actual %b", $time, want.ok, out_if.line_valid);
          errors++;
        end
        if (out_if.object_literal !== want.lit) begin
          $display("%0t: object_literal expected %b actual %b", $time, want.lit,
                   out_if.object_literal);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_tokens.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic held;
    logic drained;
    held          = 1'b0;
    drained       = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.kind    = KIND_CHAR;
    in_if.char_in = 8'h00;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirCount; i++)
      send_beat(DirRows[i].k, DirRows[i].c, DirRows[i].typed, DirRows[i].want);

    while (beats_sent < TotalBeats) begin
      if (!held && beats_sent >= 300) begin
        hold_req = 400;
        held     = 1'b1;
      end
      if (!drained && beats_sent >= 700) begin
        drain_results();
        drained = 1'b1;
      end
      calm = (beats_sent >= 900 && beats_sent < 1050);
      if ($urandom_range(0, 9) < 7) build_triple_line();
      else build_noise_line();
      foreach (line_bytes[i]) send_beat(KIND_CHAR, line_bytes[i], 1'b0, '0);
      send_beat(KIND_EOL, 8'($urandom), 1'b0, '0);
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d lines in %0d beats; %0d results checked, %0d valid triples, %0d literal.",
             lines_sent, beats_sent, results_seen, valid_lines, literal_lines);
    $display("Input beats held back by back-pressure for %0d cycles.", input_stalls);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
